/* design/lsp_pkg.sv */
package lsp_pkg;

   // Palette and scaling constants.
   localparam int PALETTE_SIZE = 8;
   localparam int PAL_W = 24;
   localparam int LEVEL_SHIFT = 8;
   localparam int PHASE_SHIFT = 10;
   localparam logic [10:0] MAX_LEDS = 11'd1024;

   // Request kinds carried on tuser.
   localparam logic ACTION_RENDER = 1'b0;
   localparam logic ACTION_PALETTE = 1'b1;

   // Control register indexes.
   localparam logic [2:0] CSR_EFFECT_MODE = 3'd0;
   localparam logic [2:0] CSR_TRANSITION_MODE = 3'd1;
   localparam logic [2:0] CSR_LED_COUNT = 3'd2;
   localparam logic [2:0] CSR_GRADIENT_COUNT = 3'd3;
   localparam logic [2:0] CSR_COLOR_START = 3'd4;
   localparam logic [2:0] CSR_BRIGHTNESS = 3'd5;
   localparam logic [2:0] CSR_CYCLE_LENGTH = 3'd6;

   // Effect codes.
   localparam logic [1:0] EFFECT_RAINBOW = 2'd1;
   localparam logic [1:0] EFFECT_SCANNER = 2'd2;

   // Transition codes.
   localparam logic [3:0] TR_GRADUAL = 4'd0;
   localparam logic [3:0] TR_OUT_IN = 4'd1;
   localparam logic [3:0] TR_IN_OUT = 4'd2;
   localparam logic [3:0] TR_OUT_IN_SOFT = 4'd3;
   localparam logic [3:0] TR_IN_OUT_SOFT = 4'd4;
   localparam logic [3:0] TR_LTR = 4'd5;
   localparam logic [3:0] TR_RTL = 4'd6;
   localparam logic [3:0] TR_LTR_SOFT = 4'd7;
   localparam logic [3:0] TR_RTL_SOFT = 4'd8;

   // Everything one request carries down the pipeline.
   typedef struct packed {
      logic        action;
      logic [9:0]  led_index;
      logic [31:0] time_now;
      logic [8:0]  dyn_level;
      logic [8:0]  dyn_factor;
      logic [2:0]  palette_slot;
      logic [23:0] palette_rgb;
      logic [10:0] n;
      logic [6:0]  half;
      logic [10:0] mark;
      logic [4:0]  seg;
      logic [14:0] n1_num;
      logic [9:0]  ph;
      logic [19:0] rb_num;
      logic [10:0] sp;
      logic [4:0]  n1;
      logic [10:0] len;
      logic [8:0]  wheel_q;
      logic [17:0] wnum;
      logic        wsat;
      logic [10:0] len_c;
      logic [2:0]  addr_a;
      logic [2:0]  addr_b;
      logic        single;
      logic [23:0] wheel_rgb;
      logic [7:0]  base_bri;
      logic        rainbow;
      logic        lit_ok;
      logic        soft_dim;
      logic [7:0]  w;
      logic [23:0] grad_rgb;
   } item_type;

endpackage

/* design/lsp_ram.sv */
module lsp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

/* design/lsp_div_pipe.sv */
module lsp_div_pipe #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 20,
   parameter int Q_W = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [Q_W-1:0]    quo,
   output logic [DEN_W-1:0]  rem,
   output logic [SIDE_W-1:0] side_out
);

   // Restoring divider, one quotient bit per stage. The bits of num above
   // the quotient width must be below den.
   logic [Q_W-1:0]    valid_ff;
   logic [DEN_W-1:0]  rem_ff [Q_W];
   logic [DEN_W-1:0]  rem_in [Q_W];
   logic [Q_W-1:0]    low_ff [Q_W];
   logic [Q_W-1:0]    low_in [Q_W];
   logic [Q_W-1:0]    quo_ff [Q_W];
   logic [Q_W-1:0]    quo_in [Q_W];
   logic [DEN_W-1:0]  den_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   // Trial subtraction of every stage.
   always_comb begin
      logic [DEN_W-1:0] r_prev;
      logic [Q_W-1:0]   l_prev;
      logic [Q_W-1:0]   q_prev;
      logic [DEN_W-1:0] d_prev;
      logic [DEN_W:0]   trial;
      logic             bit_q;
      for (int s = 0; s < Q_W; s++) begin
         if (s == 0) begin
            r_prev = DEN_W'(num >> Q_W);
            l_prev = num[Q_W-1:0];
            q_prev = '0;
            d_prev = den;
         end else begin
            r_prev = rem_ff[s-1];
            l_prev = low_ff[s-1];
            q_prev = quo_ff[s-1];
            d_prev = den_ff[s-1];
         end
         trial = {r_prev, l_prev[Q_W-1]};
         bit_q = (trial >= {1'b0, d_prev});
         if (bit_q) begin
            rem_in[s] = DEN_W'(trial - {1'b0, d_prev});
         end else begin
            rem_in[s] = trial[DEN_W-1:0];
         end
         low_in[s] = l_prev << 1;
         quo_in[s] = Q_W'({q_prev, bit_q});
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= Q_W'({valid_ff, in_valid});
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < Q_W; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            if (s == 0) begin
               den_ff[s]  <= den;
               side_ff[s] <= side_in;
            end else begin
               den_ff[s]  <= den_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign quo = quo_ff[Q_W-1];
   assign rem = rem_ff[Q_W-1];
   assign side_out = side_ff[Q_W-1];

endmodule

/* design/led_strip_pixel_effect.sv */
// Pixel effect pipeline for an LED strip. A render request (tuser 0) yields
// one response holding RGB and brightness for that pixel; a palette request
// (tuser 1) writes one of eight palette entries and yields no response.
// Requests are taken one per clock while no response waits on rsp_tready;
// each passes through the input register, the chain of bit-per-stage
// dividers (time modulo cycle length, phase, gradient segment, rainbow
// position and blend weight) and the registers between them. The whole
// pipeline holds while a response waits on rsp_tready. Control registers may
// only be written while no request is in flight.
module led_strip_pixel_effect (
   input  logic        clock,
   input  logic        reset,
   // tdata: led_index[9:0], time_now[41:10], dyn_level[50:42],
   // dyn_factor[59:51], palette_slot[62:60], palette_red[70:63],
   // palette_green[78:71], palette_blue[86:79], zero[87]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   // tuser: action[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: red[7:0], green[15:8], blue[23:16], pixel_brightness[31:24]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   localparam int ITEM_W = $bits(lsp_pkg::item_type);

   function automatic logic [7:0] sat8(input logic [8:0] v);
      return v[8] ? 8'hFF : v[7:0];
   endfunction

   // Control registers.
   logic [1:0]  effect_ff;
   logic [3:0]  trans_ff;
   logic [10:0] led_count_ff;
   logic [4:0]  grad_count_ff;
   logic [2:0]  color_start_ff;
   logic [7:0]  brightness_ff;
   logic [19:0] cycle_ff;

   logic pipe_en;
   logic [19:0] cyc_c;

   logic                s0_valid_ff, p_valid_ff, q_valid_ff, r_valid_ff, s_valid_ff;
   lsp_pkg::item_type   s0_in, s0_ff, p_in, p_ff, q_in, q_ff, r_in, r_ff, s_in, s_ff;
   logic                d1_valid, d2_valid, d3_valid, d4_valid, d5_valid, d6_valid;
   logic [ITEM_W-1:0]   d1_side, d2_side, d3_side, d4_side, d5_side, d6_side;
   logic [ITEM_W-1:0]   d4_side_in, d5_side_in;
   logic [19:0]         d1_rem;
   logic [9:0]          d2_quo;
   logic [4:0]          d3_quo;
   logic [10:0]         d4_quo;
   logic [8:0]          d5_quo;
   logic [7:0]          d6_quo;
   lsp_pkg::item_type   d2_item, d3_item, d4_item, d5_item, d6_item;

   logic [lsp_pkg::PALETTE_SIZE-1:0] pal_valid_ff;
   logic        pal_wr;
   logic [23:0] ram_a, ram_b;
   logic        ram_va_ff, ram_vb_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        out_lit_ff;

   assign csr_ready = 1'b1;
   assign pipe_en = ~rsp_valid_ff | rsp_tready;
   assign req_tready = pipe_en;
   assign cyc_c = (cycle_ff == 20'd0) ? 20'd1 : cycle_ff;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         effect_ff      <= 2'd0;
         trans_ff       <= 4'd0;
         led_count_ff   <= 11'd60;
         grad_count_ff  <= 5'd1;
         color_start_ff <= 3'd0;
         brightness_ff  <= 8'd255;
         cycle_ff       <= 20'd10000;
      end else if (csr_valid) begin
         unique case (csr_index)
            lsp_pkg::CSR_EFFECT_MODE:     effect_ff      <= csr_data[1:0];
            lsp_pkg::CSR_TRANSITION_MODE: trans_ff       <= csr_data[3:0];
            lsp_pkg::CSR_LED_COUNT:       led_count_ff   <= csr_data[10:0];
            lsp_pkg::CSR_GRADIENT_COUNT:  grad_count_ff  <= csr_data[4:0];
            lsp_pkg::CSR_COLOR_START:     color_start_ff <= csr_data[2:0];
            lsp_pkg::CSR_BRIGHTNESS:      brightness_ff  <= csr_data[7:0];
            lsp_pkg::CSR_CYCLE_LENGTH:    cycle_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // Input stage: unpack, clamp the strip length, early products.
   always_comb begin
      logic [10:0] n_c;
      logic [17:0] half_p;
      logic [19:0] mark_p;
      s0_in = '0;
      n_c = (led_count_ff == 11'd0) ? 11'd1 :
            (led_count_ff > lsp_pkg::MAX_LEDS) ? lsp_pkg::MAX_LEDS : led_count_ff;
      s0_in.action       = req_tuser;
      s0_in.led_index    = req_tdata[9:0];
      s0_in.time_now     = req_tdata[41:10];
      s0_in.dyn_level    = req_tdata[50:42];
      s0_in.dyn_factor   = req_tdata[59:51];
      s0_in.palette_slot = req_tdata[62:60];
      s0_in.palette_rgb  = {req_tdata[70:63], req_tdata[78:71], req_tdata[86:79]};
      s0_in.n            = n_c;
      // n / 10 through a reciprocal, exact for n up to 1024.
      half_p = 18'(n_c) * 18'd205;
      s0_in.half = half_p[17:11];
      mark_p = 20'(req_tdata[50:42]) * 20'(n_c);
      s0_in.mark = mark_p[18:8];
      s0_in.seg = grad_count_ff - 5'd1;
      s0_in.n1_num = 15'(req_tdata[9:0]) * 15'(s0_in.seg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_ff <= s0_in;
      end
   end

   // Time modulo the cycle length.
   lsp_div_pipe #(.NUM_W(32), .DEN_W(20), .Q_W(32), .SIDE_W(ITEM_W)) u_div_time (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(s0_valid_ff),
      .num(s0_ff.time_now), .den(cyc_c), .side_in(ITEM_W'(s0_ff)),
      .out_valid(d1_valid), .quo(), .rem(d1_rem), .side_out(d1_side)
   );

   // Phase within the cycle, scaled to 1024 steps.
   lsp_div_pipe #(.NUM_W(30), .DEN_W(20), .Q_W(10), .SIDE_W(ITEM_W)) u_div_phase (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(d1_valid),
      .num({d1_rem, 10'd0}), .den(cyc_c), .side_in(d1_side),
      .out_valid(d2_valid), .quo(d2_quo), .rem(), .side_out(d2_side)
   );

   // Phase stage: rainbow offset and scanner position.
   always_comb begin
      logic [20:0] off_p;
      logic [11:0] rb_sum;
      logic [9:0]  phf;
      logic [20:0] sp_p;
      d2_item = lsp_pkg::item_type'(d2_side);
      p_in = d2_item;
      p_in.ph = d2_quo;
      off_p = 21'(d2_quo) * 21'(d2_item.n);
      rb_sum = 12'(d2_item.led_index) + 12'(off_p[20:10]);
      p_in.rb_num = {rb_sum, 8'd0};
      // The scanner folds its phase at the half period.
      phf = (d2_quo > 10'd512) ? 10'(11'd1024 - 11'(d2_quo)) : d2_quo;
      sp_p = 21'(phf) * 21'(d2_item.n);
      p_in.sp = sp_p[19:9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         p_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p_ff <= p_in;
      end
   end

   // Gradient segment of this pixel.
   lsp_div_pipe #(.NUM_W(15), .DEN_W(11), .Q_W(5), .SIDE_W(ITEM_W)) u_div_seg (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(p_valid_ff),
      .num(p_ff.n1_num), .den(p_ff.n), .side_in(ITEM_W'(p_ff)),
      .out_valid(d3_valid), .quo(d3_quo), .rem(), .side_out(d3_side)
   );

   always_comb begin
      d3_item = lsp_pkg::item_type'(d3_side);
      d3_item.n1 = d3_quo;
      d4_side_in = ITEM_W'(d3_item);
   end

   // Segment length in pixels.
   lsp_div_pipe #(.NUM_W(11), .DEN_W(5), .Q_W(11), .SIDE_W(ITEM_W)) u_div_len (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(d3_valid),
      .num(d3_item.n), .den(d3_item.seg), .side_in(d4_side_in),
      .out_valid(d4_valid), .quo(d4_quo), .rem(), .side_out(d4_side)
   );

   always_comb begin
      d4_item = lsp_pkg::item_type'(d4_side);
      d4_item.len = d4_quo;
      d5_side_in = ITEM_W'(d4_item);
   end

   // Rainbow wheel position.
   lsp_div_pipe #(.NUM_W(20), .DEN_W(11), .Q_W(9), .SIDE_W(ITEM_W)) u_div_wheel (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(d4_valid),
      .num(d4_item.rb_num), .den(d4_item.n), .side_in(d5_side_in),
      .out_valid(d5_valid), .quo(d5_quo), .rem(), .side_out(d5_side)
   );

   // Weight setup, wheel color, scanner band and transition mask.
   always_comb begin
      logic [10:0] len_c;
      logic [15:0] prod;
      logic [9:0]  pos;
      logic [17:0] wnum;
      logic [7:0]  pq, q2, q3, t3;
      logic [11:0] lo_sum, hi_sum;
      logic        outside;
      logic [10:0] twice, diff, pt_oi, pt_e;
      logic        lit;
      d5_item = lsp_pkg::item_type'(d5_side);
      q_in = d5_item;
      q_in.wheel_q = d5_quo;
      len_c = (d5_item.len == 11'd0) ? 11'd1 : d5_item.len;
      q_in.len_c = len_c;
      prod = 16'(len_c) * 16'(d5_item.n1);
      pos = (prod > 16'(d5_item.led_index)) ? 10'd0 :
            10'(16'(d5_item.led_index) - prod);
      wnum = {pos, 8'd0} - 18'(pos);
      q_in.wnum = wnum;
      q_in.wsat = (11'(wnum[17:8]) >= len_c);

      // Color wheel.
      pq = 8'd255 - d5_quo[7:0];
      q2 = pq - 8'd85;
      q3 = pq - 8'd170;
      if (pq < 8'd85) begin
         t3 = 8'({pq, 1'b0} + 9'(pq));
         q_in.wheel_rgb = {8'd255 - t3, 8'd0, t3};
      end else if (pq < 8'd170) begin
         t3 = 8'({q2, 1'b0} + 9'(q2));
         q_in.wheel_rgb = {8'd0, t3, 8'd255 - t3};
      end else begin
         t3 = 8'({q3, 1'b0} + 9'(q3));
         q_in.wheel_rgb = {t3, 8'd255 - t3, 8'd0};
      end

      // Scanner band.
      lo_sum = 12'(d5_item.led_index) + 12'(d5_item.half);
      hi_sum = 12'(d5_item.sp) + 12'(d5_item.half);
      outside = (lo_sum < 12'(d5_item.sp)) || (12'(d5_item.led_index) > hi_sum);
      q_in.base_bri = (effect_ff == lsp_pkg::EFFECT_SCANNER && outside) ?
                      (brightness_ff >> 2) : brightness_ff;
      q_in.rainbow = (effect_ff == lsp_pkg::EFFECT_RAINBOW);

      // Palette addresses wrap around the table.
      q_in.single = (grad_count_ff <= 5'd1);
      q_in.addr_a = q_in.single ? color_start_ff : color_start_ff + d5_item.n1[2:0];
      q_in.addr_b = color_start_ff + d5_item.n1[2:0] + 3'd1;

      // Transition mask.
      twice = {d5_item.led_index, 1'b1};
      diff = (d5_item.n >= twice) ? d5_item.n - twice : twice - d5_item.n;
      pt_oi = d5_item.n - diff;
      pt_e = (trans_ff == lsp_pkg::TR_RTL || trans_ff == lsp_pkg::TR_RTL_SOFT) ?
             d5_item.n - 11'(d5_item.led_index) - 11'd1 : 11'(d5_item.led_index);
      q_in.soft_dim = 1'b0;
      unique case (trans_ff)
         lsp_pkg::TR_GRADUAL: begin
            lit = 1'b1;
            q_in.soft_dim = 1'b1;
         end
         lsp_pkg::TR_OUT_IN, lsp_pkg::TR_OUT_IN_SOFT: begin
            lit = pt_oi < d5_item.mark;
            q_in.soft_dim = (trans_ff == lsp_pkg::TR_OUT_IN_SOFT);
         end
         lsp_pkg::TR_IN_OUT, lsp_pkg::TR_IN_OUT_SOFT: begin
            lit = diff < d5_item.mark;
            q_in.soft_dim = (trans_ff == lsp_pkg::TR_IN_OUT_SOFT);
         end
         lsp_pkg::TR_LTR, lsp_pkg::TR_RTL, lsp_pkg::TR_LTR_SOFT, lsp_pkg::TR_RTL_SOFT: begin
            lit = pt_e < d5_item.mark;
            q_in.soft_dim = (trans_ff == lsp_pkg::TR_LTR_SOFT) ||
                            (trans_ff == lsp_pkg::TR_RTL_SOFT);
         end
         default: begin
            lit = (d5_item.dyn_level != 9'd0);
         end
      endcase
      q_in.lit_ok = lit && (11'(d5_item.led_index) < d5_item.n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         q_valid_ff <= d5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         q_ff <= q_in;
      end
   end

   // Blend weight inside the segment.
   lsp_div_pipe #(.NUM_W(18), .DEN_W(11), .Q_W(8), .SIDE_W(ITEM_W)) u_div_weight (
      .clock(clock), .reset(reset), .en(pipe_en), .in_valid(q_valid_ff),
      .num(q_ff.wnum), .den(q_ff.len_c), .side_in(ITEM_W'(q_ff)),
      .out_valid(d6_valid), .quo(d6_quo), .rem(), .side_out(d6_side)
   );

   // Palette access: writes and reads happen at the same stage, so the
   // request order is kept.
   always_comb begin
      d6_item = lsp_pkg::item_type'(d6_side);
      r_in = d6_item;
      r_in.w = d6_item.wsat ? 8'd255 : d6_quo;
      pal_wr = pipe_en && d6_valid && (d6_item.action == lsp_pkg::ACTION_PALETTE);
   end

   lsp_ram #(.WIDTH(lsp_pkg::PAL_W), .DEPTH(lsp_pkg::PALETTE_SIZE)) u_palette (
      .clock(clock), .wr_en(pal_wr), .wr_addr(d6_item.palette_slot),
      .wr_data(d6_item.palette_rgb), .rd_en(pipe_en),
      .rd_addr_a(d6_item.addr_a), .rd_addr_b(d6_item.addr_b),
      .rd_data_a(ram_a), .rd_data_b(ram_b)
   );

   // Entries never written read as black.
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (pal_wr) begin
         pal_valid_ff[d6_item.palette_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         r_valid_ff <= d6_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         r_ff <= r_in;
         ram_va_ff <= pal_valid_ff[d6_item.addr_a];
         ram_vb_ff <= pal_valid_ff[d6_item.addr_b];
      end
   end

   // Gradient blend between two palette entries.
   always_comb begin
      logic [23:0] ca, cb;
      logic [16:0] sum;
      logic [7:0]  iw;
      ca = ram_va_ff ? ram_a : 24'd0;
      cb = ram_vb_ff ? ram_b : 24'd0;
      iw = 8'd255 - r_ff.w;
      s_in = r_ff;
      for (int c = 0; c < 3; c++) begin
         sum = 17'(ca[c*8 +: 8]) * 17'(iw) + 17'(cb[c*8 +: 8]) * 17'(r_ff.w);
         s_in.grad_rgb[c*8 +: 8] = r_ff.single ? ca[c*8 +: 8] : sum[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s_ff <= s_in;
      end
   end

   // Intensity scaling, effect choice, soft brightness and masking.
   always_comb begin
      logic [16:0] fp, bp;
      logic [23:0] scaled, color;
      logic [7:0]  bri;
      for (int c = 0; c < 3; c++) begin
         fp = 17'(s_ff.dyn_factor) * 17'(s_ff.grad_rgb[c*8 +: 8]);
         scaled[c*8 +: 8] = sat8(fp[16:8]);
      end
      color = s_ff.rainbow ? s_ff.wheel_rgb : scaled;
      bp = 17'(s_ff.base_bri) * 17'(s_ff.dyn_level);
      bri = s_ff.soft_dim ? sat8(bp[16:8]) : s_ff.base_bri;
      rsp_valid_in = s_valid_ff && (s_ff.action == lsp_pkg::ACTION_RENDER);
      rsp_data_in = s_ff.lit_ok ? {bri, color[7:0], color[15:8], color[23:16]} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
         out_lit_ff  <= s_ff.lit_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Palette entries, once written, stay valid.
   assert property (@(posedge clock) disable iff (reset)
      ($past(pal_valid_ff) & ~pal_valid_ff) == '0)
      else $error("palette valid bit dropped");

   // A held pipeline keeps its stages.
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(r_valid_ff) && $stable(s_valid_ff))
      else $error("pipeline moved while stalled");

   // A masked or off-strip pixel is black.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_lit_ff |-> rsp_tdata == 32'd0)
      else $error("masked pixel not black");

endmodule
